>>> sv/fpsm_pkg.sv
// ----------------------------------------------------------------------------
// fpsm_pkg: shared definitions for the fixed-priority scheduler with monitor
// Sizes, field widths and the control structures exchanged between the
// top level, the task cells and the deadline-miss monitor.
// ----------------------------------------------------------------------------
package fpsm_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int WINDOW_LEN = 8;

    localparam int SLOT_W   = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int POS_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CMP_W    = 6;
    localparam int TIME_W   = 32;
    localparam int SHORT_W  = 16;
    localparam int COUNT_W  = 7;
    localparam int RUN_W    = 4;
    localparam int TIDX_W   = 3;
    localparam int CFG_W    = 32;
    localparam int CFGIDX_W = 2;

    localparam logic [RUN_W-1:0] IDLE_CODE = RUN_W'(8);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [CFGIDX_W-1:0] {
        REG_MONITORED  = 2'd0,
        REG_MISS_LIMIT = 2'd1,
        REG_TIME_LIMIT = 2'd2
    } cfg_reg_t;

    // Per-cell control from the top level.
    typedef struct packed {
        logic load;     // this slot is written by the current request
        logic tick;     // a tick is being executed this cycle
        logic advance;  // a finishing job may move on to its next period
    } cell_ctrl_t;

    // Per-cell status back to the top level.
    typedef struct packed {
        logic grant;    // this cell takes the time unit
        logic finish;   // the granted job completes on this tick
    } cell_stat_t;

    // Monitor results for the current request.
    typedef struct packed {
        logic [COUNT_W-1:0] count_next;
        logic               violation_now;
        logic               violation_next;
    } mon_stat_t;

endpackage

>>> sv/fpsm_cell.sv
// ----------------------------------------------------------------------------
// fpsm_cell: one task slot of the scheduler row
// Holds the slot's period, job length, release, deadline and remaining work,
// and passes the priority claim on to the next, lower-priority cell.
// ----------------------------------------------------------------------------
module fpsm_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fpsm_pkg::cell_ctrl_t            ctrl,
    input  logic [fpsm_pkg::SHORT_W-1:0]    ld_period,
    input  logic [fpsm_pkg::SHORT_W-1:0]    ld_wcet,
    input  logic [fpsm_pkg::TIME_W-1:0]     ld_release,
    input  logic [fpsm_pkg::TIME_W-1:0]     ld_deadline,
    input  logic [fpsm_pkg::TIME_W-1:0]     current_time,
    input  logic                            taken_in,
    output logic                            taken_out,
    output fpsm_pkg::cell_stat_t            stat,
    output logic [fpsm_pkg::TIME_W-1:0]     deadline
);

    logic [fpsm_pkg::TIME_W-1:0]  release_reg;
    logic [fpsm_pkg::TIME_W-1:0]  deadline_reg;
    logic [fpsm_pkg::SHORT_W-1:0] period_reg;
    logic [fpsm_pkg::SHORT_W-1:0] length_reg;
    logic [fpsm_pkg::SHORT_W-1:0] work_reg;
    logic [fpsm_pkg::SHORT_W-1:0] work_next;
    logic                         eligible;
    logic                         roll;

    assign eligible    = (work_reg != '0) && (release_reg <= current_time);
    assign stat.grant  = eligible && !taken_in;
    assign stat.finish = stat.grant && (work_reg == fpsm_pkg::SHORT_W'(1));
    assign taken_out   = taken_in || eligible;
    assign deadline    = deadline_reg;

    // The job rolls over to its next period unless the monitor halts the block.
    assign roll = ctrl.tick && stat.finish && ctrl.advance;

    always_comb
    begin
        work_next = work_reg;
        if (ctrl.load)
        begin
            work_next = ld_wcet;
        end
        else if (ctrl.tick && stat.grant)
        begin
            work_next = roll ? length_reg : work_reg - fpsm_pkg::SHORT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
        end
        else
        begin
            work_reg <= work_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            period_reg   <= ld_period;
            length_reg   <= ld_wcet;
            release_reg  <= ld_release;
            deadline_reg <= ld_deadline;
        end
        else if (roll)
        begin
            release_reg  <= release_reg + fpsm_pkg::TIME_W'(period_reg);
            deadline_reg <= deadline_reg + fpsm_pkg::TIME_W'(period_reg);
        end
    end

endmodule

>>> sv/fpsm_monitor.sv
// ----------------------------------------------------------------------------
// fpsm_monitor: (m,k)-firm deadline-miss window
// Circular window of miss bits for the monitored task, a running miss count
// and the sticky violation flag.
// ----------------------------------------------------------------------------
module fpsm_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            record,
    input  logic                            missed,
    input  logic [fpsm_pkg::COUNT_W-1:0]    miss_limit,
    output fpsm_pkg::mon_stat_t             stat
);

    logic [fpsm_pkg::WINDOW_LEN-1:0] window_reg;
    logic [fpsm_pkg::WINDOW_LEN-1:0] window_next;
    logic [fpsm_pkg::POS_W-1:0]      pos_reg;
    logic [fpsm_pkg::POS_W-1:0]      pos_next;
    logic [fpsm_pkg::COUNT_W-1:0]    count_reg;
    logic                            violation_reg;
    logic                            old_bit;

    assign old_bit = window_reg[pos_reg];

    // The count tracks the window incrementally: the overwritten entry leaves,
    // the new outcome enters.
    always_comb
    begin
        window_next     = window_reg;
        pos_next        = pos_reg;
        stat.count_next = count_reg;
        if (record)
        begin
            window_next[pos_reg] = missed;
            stat.count_next = count_reg - fpsm_pkg::COUNT_W'(old_bit)
                              + fpsm_pkg::COUNT_W'(missed);
        end
        stat.violation_now  = record && (stat.count_next > miss_limit);
        stat.violation_next = violation_reg || stat.violation_now;
        if (record && !stat.violation_now)
        begin
            pos_next = (pos_reg == fpsm_pkg::POS_W'(fpsm_pkg::WINDOW_LEN - 1))
                       ? '0 : pos_reg + fpsm_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            violation_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            pos_reg       <= pos_next;
            count_reg     <= stat.count_next;
            violation_reg <= stat.violation_next;
        end
    end

endmodule

>>> sv/fixed_priority_scheduler_mk_monitor.sv
// ----------------------------------------------------------------------------
// fixed_priority_scheduler_mk_monitor: periodic task scheduler with monitor
// Fixed-priority preemptive scheduler over a row of task cells, with an
// (m,k)-firm deadline-miss check on one selected task.
// ----------------------------------------------------------------------------
// Every request (a task load or a scheduling tick) yields its response in the
// following cycle through an output register; a new request is taken each
// cycle while the response side keeps up. The cycle is set by the priority
// claim rippling through the row of task cells, followed by the deadline
// compare and the miss-count update of the granted job. Loads are taken at
// any time, also after the block has halted.
module fixed_priority_scheduler_mk_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fpsm_pkg::CFGIDX_W-1:0]   cfg_index,
    input  logic [fpsm_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic                            operation,
    input  logic [fpsm_pkg::TIDX_W-1:0]     task_index,
    input  logic [fpsm_pkg::SHORT_W-1:0]    task_period,
    input  logic [fpsm_pkg::SHORT_W-1:0]    task_wcet,
    input  logic [fpsm_pkg::TIME_W-1:0]     first_release,
    input  logic [fpsm_pkg::TIME_W-1:0]     first_deadline,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [fpsm_pkg::RUN_W-1:0]      running_task,
    output logic                            job_completed,
    output logic                            deadline_missed,
    output logic [fpsm_pkg::COUNT_W-1:0]    miss_count,
    output logic                            violation,
    output logic                            halted
);

    localparam int N = fpsm_pkg::TASK_SLOTS;

    logic [fpsm_pkg::TIDX_W-1:0]  monitored_reg;
    logic [fpsm_pkg::COUNT_W-1:0] miss_limit_reg;
    logic [fpsm_pkg::TIME_W-1:0]  time_limit_reg;
    logic [fpsm_pkg::TIME_W-1:0]  time_reg;
    logic                         stopped_reg;
    logic                         stopped_next;

    logic                         rsp_valid_reg;
    logic [fpsm_pkg::RUN_W-1:0]   running_reg;
    logic                         completed_reg;
    logic                         missed_reg;
    logic [fpsm_pkg::COUNT_W-1:0] count_reg;
    logic                         violation_reg;
    logic                         halted_reg;

    logic                         accept;
    logic                         is_load;
    logic                         tick_fire;
    logic                         time_hit;
    logic                         tick_go;
    logic                         halt_now;

    logic [N:0]                   taken;
    fpsm_pkg::cell_ctrl_t         cell_ctrl [N];
    fpsm_pkg::cell_stat_t         cell_stat [N];
    logic [fpsm_pkg::TIME_W-1:0]  cell_deadline [N];

    logic [fpsm_pkg::SLOT_W-1:0]  grant_idx;
    logic [fpsm_pkg::TIME_W-1:0]  grant_deadline;
    logic                         grant_any;
    logic                         finish_any;
    logic                         mon_match;
    logic                         record;
    logic                         missed;
    fpsm_pkg::mon_stat_t          mon_stat;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign is_load   = (fpsm_pkg::op_t'(operation) == fpsm_pkg::OP_LOAD);
    assign tick_fire = accept && !is_load && !stopped_reg;
    assign time_hit  = (time_reg >= time_limit_reg);
    assign tick_go   = tick_fire && !time_hit;
    assign halt_now  = mon_stat.violation_now;

    // Row of task cells; the lowest index holds the highest priority.
    assign taken[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            assign cell_ctrl[g].load = accept && is_load
                && (fpsm_pkg::CMP_W'(task_index) == fpsm_pkg::CMP_W'(g));
            assign cell_ctrl[g].tick    = tick_go;
            assign cell_ctrl[g].advance = !halt_now;

            fpsm_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (cell_ctrl[g]),
                .ld_period    (task_period),
                .ld_wcet      (task_wcet),
                .ld_release   (first_release),
                .ld_deadline  (first_deadline),
                .current_time (time_reg),
                .taken_in     (taken[g]),
                .taken_out    (taken[g+1]),
                .stat         (cell_stat[g]),
                .deadline     (cell_deadline[g])
            );
        end
    endgenerate

    assign grant_any = taken[N];

    // At most one cell grants, so the index and deadline are simple OR merges.
    always_comb
    begin
        grant_idx      = '0;
        grant_deadline = '0;
        finish_any     = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            if (cell_stat[i].grant)
            begin
                grant_idx      = grant_idx | fpsm_pkg::SLOT_W'(i);
                grant_deadline = grant_deadline | cell_deadline[i];
            end
            finish_any = finish_any | cell_stat[i].finish;
        end
    end

    assign mon_match = (fpsm_pkg::CMP_W'(monitored_reg) < fpsm_pkg::CMP_W'(N))
        && (fpsm_pkg::CMP_W'(grant_idx) == fpsm_pkg::CMP_W'(monitored_reg));
    assign record = tick_go && finish_any && mon_match;
    assign missed = record && (time_reg > grant_deadline);

    fpsm_monitor u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .record     (record),
        .missed     (missed),
        .miss_limit (miss_limit_reg),
        .stat       (mon_stat)
    );

    assign stopped_next = stopped_reg || (tick_fire && time_hit) || halt_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            monitored_reg  <= '0;
            miss_limit_reg <= fpsm_pkg::COUNT_W'(1);
            time_limit_reg <= '1;
            time_reg       <= '0;
            stopped_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (fpsm_pkg::cfg_reg_t'(cfg_index))
                    fpsm_pkg::REG_MONITORED:
                        monitored_reg  <= cfg_data[fpsm_pkg::TIDX_W-1:0];
                    fpsm_pkg::REG_MISS_LIMIT:
                        miss_limit_reg <= cfg_data[fpsm_pkg::COUNT_W-1:0];
                    fpsm_pkg::REG_TIME_LIMIT:
                        time_limit_reg <= cfg_data[fpsm_pkg::TIME_W-1:0];
                    default:        ;
                endcase
            end
            if (tick_go && !halt_now)
            begin
                time_reg <= time_reg + fpsm_pkg::TIME_W'(1);
            end
            stopped_reg <= stopped_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            running_reg   <= (tick_go && grant_any)
                             ? fpsm_pkg::RUN_W'(grant_idx) : fpsm_pkg::IDLE_CODE;
            completed_reg <= tick_go && finish_any;
            missed_reg    <= missed;
            count_reg     <= mon_stat.count_next;
            violation_reg <= mon_stat.violation_next;
            halted_reg    <= stopped_next;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign running_task    = running_reg;
    assign job_completed   = completed_reg;
    assign deadline_missed = missed_reg;
    assign miss_count      = count_reg;
    assign violation       = violation_reg;
    assign halted          = halted_reg;

endmodule

>>> test/tb_fixed_priority_scheduler_mk_monitor.sv
// ----------------------------------------------------------------------------
// tb_fixed_priority_scheduler_mk_monitor: self-checking bench for the scheduler
// Drives task loads and scheduling ticks through the request channel with
// bursty traffic and a stalling response side. A scoreboard class keeps its
// own copy of the task table and the miss window, predicts one response per
// request and compares every response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
    fpsm_pkg::op_t                op;
    logic [fpsm_pkg::TIDX_W-1:0]  slot;
    logic [fpsm_pkg::SHORT_W-1:0] period;
    logic [fpsm_pkg::SHORT_W-1:0] wcet;
    logic [fpsm_pkg::TIME_W-1:0]  rel;
    logic [fpsm_pkg::TIME_W-1:0]  due;
} sched_req_t;

typedef struct packed {
    logic [fpsm_pkg::RUN_W-1:0]   running;
    logic                         done;
    logic                         missed;
    logic [fpsm_pkg::COUNT_W-1:0] count;
    logic                         viol;
    logic                         halt;
} sched_grant_t;

class schedule_checker;
    logic [fpsm_pkg::TIME_W-1:0]  release_at [fpsm_pkg::TASK_SLOTS];
    logic [fpsm_pkg::TIME_W-1:0]  due_at     [fpsm_pkg::TASK_SLOTS];
    logic [fpsm_pkg::SHORT_W-1:0] work_left  [fpsm_pkg::TASK_SLOTS];
    logic [fpsm_pkg::SHORT_W-1:0] job_len    [fpsm_pkg::TASK_SLOTS];
    logic [fpsm_pkg::SHORT_W-1:0] period_of  [fpsm_pkg::TASK_SLOTS];
    logic [fpsm_pkg::TIME_W-1:0]  now;
    logic [63:0]                  miss_bits;
    int                           win_pos;
    bit                           stopped;
    bit                           violated;
    logic [fpsm_pkg::TIDX_W-1:0]  watched;
    logic [fpsm_pkg::COUNT_W-1:0] miss_budget;
    logic [fpsm_pkg::TIME_W-1:0]  stop_at;
    sched_grant_t                 expected_grants[$];
    int                           errors;
    int                           loads;
    int                           ticks;
    int                           grants;
    int                           completions;
    int                           misses;

    function new();
        for (int i = 0; i < fpsm_pkg::TASK_SLOTS; i++)
        begin
            release_at[i] = '0;
            due_at[i]     = '0;
            work_left[i]  = '0;
            job_len[i]    = '0;
            period_of[i]  = '0;
        end
        now         = '0;
        miss_bits   = '0;
        win_pos     = 0;
        stopped     = 1'b0;
        violated    = 1'b0;
        watched     = '0;
        miss_budget = fpsm_pkg::COUNT_W'(1);
        stop_at     = '1;
        errors      = 0;
        loads       = 0;
        ticks       = 0;
        grants      = 0;
        completions = 0;
        misses      = 0;
    endfunction

    function void write_register(fpsm_pkg::cfg_reg_t idx,
                                 logic [fpsm_pkg::CFG_W-1:0] value);
        case (idx)
            fpsm_pkg::REG_MONITORED:  watched     = value[fpsm_pkg::TIDX_W-1:0];
            fpsm_pkg::REG_MISS_LIMIT: miss_budget = value[fpsm_pkg::COUNT_W-1:0];
            fpsm_pkg::REG_TIME_LIMIT: stop_at     = value[fpsm_pkg::TIME_W-1:0];
            default: ;
        endcase
    endfunction

    // Advances the predicted state by one accepted request and queues the response.
    function void note_request(sched_req_t r);
        sched_grant_t g;
        int           slot;
        bit           halt_now;
        logic [63:0]  bit_mask;
        g = '0;
        g.running = fpsm_pkg::IDLE_CODE;
        halt_now = 1'b0;
        if (r.op == fpsm_pkg::OP_LOAD)
        begin
            loads++;
            if (int'(r.slot) < fpsm_pkg::TASK_SLOTS)
            begin
                period_of[r.slot]  = r.period;
                job_len[r.slot]    = r.wcet;
                release_at[r.slot] = r.rel;
                due_at[r.slot]     = r.due;
                work_left[r.slot]  = r.wcet;
            end
        end
        else
        begin
            ticks++;
            if (!stopped)
            begin
                if (now >= stop_at)
                    stopped = 1'b1;
                else
                begin
                    slot = fpsm_pkg::TASK_SLOTS;
                    for (int i = fpsm_pkg::TASK_SLOTS - 1; i >= 0; i--)
                        if (work_left[i] != '0 && release_at[i] <= now)
                            slot = i;
                    if (slot < fpsm_pkg::TASK_SLOTS)
                    begin
                        g.running = fpsm_pkg::RUN_W'(slot);
                        grants++;
                        work_left[slot] = work_left[slot] - 1'b1;
                        if (work_left[slot] == '0)
                        begin
                            g.done = 1'b1;
                            completions++;
                            if (slot == int'(watched))
                            begin
                                bit_mask = 64'd1 << (win_pos & 63);
                                g.missed = (now > due_at[slot]);
                                if (g.missed)
                                begin
                                    miss_bits = miss_bits | bit_mask;
                                    misses++;
                                end
                                else
                                    miss_bits = miss_bits & ~bit_mask;
                                if ($countones(miss_bits) > int'(miss_budget))
                                begin
                                    violated = 1'b1;
                                    stopped  = 1'b1;
                                    halt_now = 1'b1;
                                end
                                else
                                    win_pos = (win_pos + 1) % fpsm_pkg::WINDOW_LEN;
                            end
                            // A violating job stays where it is and time freezes.
                            if (!halt_now)
                            begin
                                release_at[slot] = release_at[slot]
                                    + fpsm_pkg::TIME_W'(period_of[slot]);
                                due_at[slot]     = due_at[slot]
                                    + fpsm_pkg::TIME_W'(period_of[slot]);
                                work_left[slot]  = job_len[slot];
                            end
                        end
                    end
                    if (!halt_now)
                        now = now + 1'b1;
                end
            end
        end
        g.count = fpsm_pkg::COUNT_W'($countones(miss_bits));
        g.viol  = violated;
        g.halt  = stopped;
        expected_grants.push_back(g);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            errors++;
        end
    endfunction

    function void check_response(sched_grant_t got);
        sched_grant_t want;
        if (expected_grants.size() == 0)
        begin
            $error("response with no request outstanding (running_task %0d)", got.running);
            errors++;
            return;
        end
        want = expected_grants.pop_front();
        compare_field("running_task", 32'(want.running), 32'(got.running));
        compare_field("job_completed", 32'(want.done), 32'(got.done));
        compare_field("deadline_missed", 32'(want.missed), 32'(got.missed));
        compare_field("miss_count", 32'(want.count), 32'(got.count));
        compare_field("violation", 32'(want.viol), 32'(got.viol));
        compare_field("halted", 32'(want.halt), 32'(got.halt));
    endfunction
endclass

module tb_fixed_priority_scheduler_mk_monitor;

    localparam int MISS_LIMIT_MAX = 64;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 350;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [fpsm_pkg::CFGIDX_W-1:0] cfg_index;
    logic [fpsm_pkg::CFG_W-1:0]    cfg_data;
    logic                          req_valid;
    logic                          req_ready;
    logic                          operation;
    logic [fpsm_pkg::TIDX_W-1:0]   task_index;
    logic [fpsm_pkg::SHORT_W-1:0]  task_period;
    logic [fpsm_pkg::SHORT_W-1:0]  task_wcet;
    logic [fpsm_pkg::TIME_W-1:0]   first_release;
    logic [fpsm_pkg::TIME_W-1:0]   first_deadline;
    logic                          rsp_valid;
    logic                          rsp_ready;
    logic [fpsm_pkg::RUN_W-1:0]    running_task;
    logic                          job_completed;
    logic                          deadline_missed;
    logic [fpsm_pkg::COUNT_W-1:0]  miss_count;
    logic                          violation;
    logic                          halted;

    schedule_checker sched_chk = new();
    int              accepted_requests = 0;
    int              burst_left = 0;

    fixed_priority_scheduler_mk_monitor dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .operation       (operation),
        .task_index      (task_index),
        .task_period     (task_period),
        .task_wcet       (task_wcet),
        .first_release   (first_release),
        .first_deadline  (first_deadline),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .running_task    (running_task),
        .job_completed   (job_completed),
        .deadline_missed (deadline_missed),
        .miss_count      (miss_count),
        .violation       (violation),
        .halted          (halted)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1)
            sched_chk.check_response(sched_grant_t'{running: running_task,
                done: job_completed, missed: deadline_missed, count: miss_count,
                viol: violation, halt: halted});
    end

    // Response side: stretches with different stall rates, plus long hold-offs
    // that back the block up into its request port.
    initial
    begin
        int stall_pct;
        int stretch;
        int next_hold;
        rsp_ready = 1'b0;
        next_hold = 400;
        wait (rst_n === 1'b1);
        forever
        begin
            stretch = $urandom_range(20, 200);
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 30;
                default: stall_pct = 70;
            endcase
            repeat (stretch)
            begin
                @(negedge clk);
                if (accepted_requests >= next_hold)
                begin
                    rsp_ready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge clk);
                    next_hold += 900;
                end
                else
                    rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_request(input sched_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid      <= 1'b1;
        operation      <= r.op;
        task_index     <= r.slot;
        task_period    <= r.period;
        task_wcet      <= r.wcet;
        first_release  <= r.rel;
        first_deadline <= r.due;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        accepted_requests++;
        sched_chk.note_request(r);
    endtask

    // Stops offering requests and waits until every response is back.
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
        while (sched_chk.expected_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input fpsm_pkg::cfg_reg_t idx,
                                  input logic [fpsm_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sched_chk.write_register(idx, value);
    endtask

    function automatic sched_req_t load_request(int slot, int period, int wcet,
                                                logic [fpsm_pkg::TIME_W-1:0] rel,
                                                logic [fpsm_pkg::TIME_W-1:0] due);
        sched_req_t r;
        r.op     = fpsm_pkg::OP_LOAD;
        r.slot   = fpsm_pkg::TIDX_W'(slot);
        r.period = fpsm_pkg::SHORT_W'(period);
        r.wcet   = fpsm_pkg::SHORT_W'(wcet);
        r.rel    = rel;
        r.due    = due;
        return r;
    endfunction

    // Tick requests carry random junk in the fields the block ignores.
    function automatic sched_req_t tick_request();
        sched_req_t r;
        r = load_request($urandom_range(0, 7), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), fpsm_pkg::TIME_W'($urandom),
                         fpsm_pkg::TIME_W'($urandom));
        r.op = fpsm_pkg::OP_TICK;
        return r;
    endfunction

    function automatic sched_req_t random_load();
        int                          kind;
        int                          slot;
        int                          per;
        logic [fpsm_pkg::TIME_W-1:0] rel;
        kind = $urandom_range(0, 19);
        slot = $urandom_range(0, fpsm_pkg::TASK_SLOTS - 1);
        per  = $urandom_range(4, 48);
        rel  = sched_chk.now + fpsm_pkg::TIME_W'($urandom_range(0, 16));
        if (kind < 2)
            return load_request(slot, $urandom_range(0, 65535), $urandom_range(0, 65535),
                                fpsm_pkg::TIME_W'($urandom), fpsm_pkg::TIME_W'($urandom));
        else if (kind < 3)
            return load_request(slot, per, 0, rel, rel + fpsm_pkg::TIME_W'(per));
        else if (kind < 4)
            return load_request(slot, 0, $urandom_range(1, 3), rel, rel + 32'd3);
        else if (kind < 5)
            return load_request(slot, per, $urandom_range(1, per / 2), rel,
                                32'hFFFF_FFFF - fpsm_pkg::TIME_W'($urandom_range(0, 3 * per)));
        else if (kind < 6)
            return load_request(slot, per, $urandom_range(per, 4 * per), rel,
                                rel + fpsm_pkg::TIME_W'(per));
        else
            return load_request(slot, per, $urandom_range(1, per / 4), rel,
                                rel + fpsm_pkg::TIME_W'($urandom_range(per / 2, per + 8)));
    endfunction

    task automatic run_phase(input int count, input int load_pct);
        repeat (4) send_request(random_load());
        repeat (count)
        begin
            if ($urandom_range(0, 99) < load_pct)
                send_request(random_load());
            else
                send_request(tick_request());
        end
    endtask

    initial
    begin
        int watch;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = fpsm_pkg::REG_MONITORED;
        cfg_data       = '0;
        req_valid      = 1'b0;
        operation      = fpsm_pkg::OP_LOAD;
        task_index     = '0;
        task_period    = '0;
        task_wcet      = '0;
        first_release  = '0;
        first_deadline = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, under the reset configuration (task 0 watched, one
        // miss allowed): empty table, zero and all-ones fields, zero work,
        // zero period, an unwatched late job, one watched miss, deadline wrap.
        send_request(tick_request());
        send_request(load_request(3, 0, 0, 32'd0, 32'd0));
        send_request(load_request(7, 65535, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(tick_request());
        send_request(load_request(0, 0, 2, sched_chk.now, 32'hFFFF_FFFF));
        repeat (4) send_request(tick_request());
        send_request(load_request(0, 5, 0, 32'd0, 32'd0));
        send_request(load_request(1, 2, 1, sched_chk.now, 32'd0));
        repeat (2) send_request(tick_request());
        send_request(load_request(2, 16, 1, sched_chk.now, 32'hFFFF_FFF8));
        send_request(load_request(0, 5, 1, sched_chk.now, sched_chk.now - 1'b1));
        send_request(tick_request());
        send_request(load_request(0, 5, 1, sched_chk.now + 32'd2, 32'hFFFF_FFF0));
        repeat (6) send_request(tick_request());

        // Main random phases. The miss limit never drops below the window
        // length here, so no violation can stop the schedule early.
        for (int p = 0; p < 4; p++)
        begin
            settle();
            write_register(fpsm_pkg::REG_MONITORED,
                           fpsm_pkg::CFG_W'($urandom_range(0, fpsm_pkg::TASK_SLOTS - 1)));
            case (p)
                0:
                begin
                    write_register(fpsm_pkg::REG_MISS_LIMIT,
                                   fpsm_pkg::CFG_W'(MISS_LIMIT_MAX));
                    write_register(fpsm_pkg::REG_TIME_LIMIT, 32'hFFFF_FFFF);
                end
                1:
                begin
                    write_register(fpsm_pkg::REG_MISS_LIMIT,
                                   fpsm_pkg::CFG_W'(fpsm_pkg::WINDOW_LEN));
                    write_register(fpsm_pkg::REG_TIME_LIMIT, sched_chk.now + 32'd100000);
                end
                2:
                begin
                    write_register(fpsm_pkg::REG_MISS_LIMIT,
                                   fpsm_pkg::CFG_W'($urandom_range(fpsm_pkg::WINDOW_LEN,
                                                                   MISS_LIMIT_MAX - 1)));
                    write_register(fpsm_pkg::REG_TIME_LIMIT, 32'hFFFF_FFFF);
                end
                default:
                    write_register(fpsm_pkg::REG_MISS_LIMIT,
                                   fpsm_pkg::CFG_W'(MISS_LIMIT_MAX));
            endcase
            run_phase(PHASE_ITEMS, 15);
        end

        // Halting is sticky, so one run ends through either a violation or the
        // time limit, and then keeps sending loads and ticks to the stopped block.
        settle();
        if ($urandom_range(0, 1) == 1)
        begin
            watch = $urandom_range(0, fpsm_pkg::TASK_SLOTS - 1);
            write_register(fpsm_pkg::REG_MONITORED, fpsm_pkg::CFG_W'(watch));
            write_register(fpsm_pkg::REG_MISS_LIMIT, fpsm_pkg::CFG_W'($urandom_range(0, 3)));
            // Deadline equal to release: every job of this task finishes late.
            send_request(load_request(watch, $urandom_range(8, 20), $urandom_range(2, 4),
                                      sched_chk.now, sched_chk.now));
            run_phase(250, 10);
        end
        else
        begin
            write_register(fpsm_pkg::REG_TIME_LIMIT,
                           sched_chk.now + fpsm_pkg::TIME_W'($urandom_range(30, 200)));
            run_phase(250, 15);
            settle();
            write_register(fpsm_pkg::REG_MISS_LIMIT, '0);
        end
        settle();
        write_register(fpsm_pkg::REG_TIME_LIMIT, '0);
        run_phase(100, 30);

        settle();
        repeat (4) @(posedge clk);
        $display("Run covered %0d requests: %0d loads, %0d ticks, %0d grants.",
                 accepted_requests, sched_chk.loads, sched_chk.ticks, sched_chk.grants);
        $display("Jobs completed %0d, watched misses %0d, ended with violation=%0b halted=%0b.",
                 sched_chk.completions, sched_chk.misses, sched_chk.violated,
                 sched_chk.stopped);
        if (sched_chk.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
sv/fpsm_pkg.sv
sv/fpsm_cell.sv
sv/fpsm_monitor.sv
sv/fixed_priority_scheduler_mk_monitor.sv
test/tb_fixed_priority_scheduler_mk_monitor.sv
